/* hw/rtl/mi44_pkg.sv */
// ----------------------------------------------------------------------------
// mi44_pkg
// Types, constants and index helpers for the 4x4 matrix inverse block.
// ----------------------------------------------------------------------------
package mi44_pkg;

   localparam int ENTRY_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int THR_W     = 63;
   localparam int COF_W     = 128;  // cofactor word, four 32-bit limbs
   localparam int DET_W     = 136;  // accumulator and determinant magnitude

   localparam logic [THR_W-1:0] THR_RESET = THR_W'(64'd18446744073709);
   localparam logic [ENTRY_W-1:0] ONE_Q   = ENTRY_W'(1) << FRAC_BITS;
   localparam logic [ENTRY_W-1:0] SAT_POS = {1'b0, {(ENTRY_W-1){1'b1}}};
   localparam logic [ENTRY_W-1:0] SAT_NEG = {1'b1, {(ENTRY_W-1){1'b0}}};

   // column permutations of a 3x3 determinant, {p2, p1, p0}
   localparam logic [5:0] PERM [6] = '{
      6'b10_01_00, 6'b00_10_01, 6'b01_00_10,
      6'b01_10_00, 6'b10_00_01, 6'b00_01_10
   };
   localparam logic [5:0] PERM_NEG = 6'b111000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RA, ST_RB, ST_RC, ST_MP, ST_ML, ST_MH, ST_AH, ST_WC,
      ST_DA, ST_DB, ST_DL, ST_ABS, ST_CHK, ST_SOUT,
      ST_QA, ST_QB, ST_QC, ST_QDIV, ST_QOUT
   } state_type;

   // k-th index of 0..3 that is not x
   function automatic logic [1:0] skip_idx(logic [1:0] x, logic [1:0] k);
      return (k < x) ? k : 2'(k + 2'd1);
   endfunction

   // store address of one factor of a minor's permutation term
   function automatic logic [3:0] minor_addr(logic [3:0] ci, logic [2:0] term,
                                             logic [1:0] pos);
      logic [5:0] p;
      logic [1:0] col;
      p   = PERM[term];
      col = p[2*pos +: 2];
      return {skip_idx(ci[3:2], pos), skip_idx(ci[1:0], col)};
   endfunction

endpackage

/* hw/rtl/matrix_inverse_4x4_top.sv */
// ----------------------------------------------------------------------------
// matrix_inverse_4x4_top
// 4x4 inverse of a Q16.16 matrix by cofactors and an exact wide determinant.
// ----------------------------------------------------------------------------
// Usage: drive req_entry_value with start high; an entry transfers at each
// edge where start is high and busy is low. Entries come in row-major order.
// After the sixteenth entry busy rises and the block computes sixteen
// cofactors (6 terms each, through one shared 33x33 multiplier), then
// the determinant and the singular check.
// Results follow on rsp_* marked by rsp_strobe, one cycle each, row-major,
// rsp_last_entry on the sixteenth. A singular matrix gives the identity
// with its entries back to back; otherwise each entry goes through the
// one-bit-per-cycle restoring divider (saturated entries skip it).
// The receiver cannot stall: a strobe is taken in the cycle it is shown.
// csr_singular_threshold is written via csr_valid/csr_ready, by the user only
// while idle (unenforced). Reset (synchronous) clears the load count, the
// sequencer, the threshold (to default); entry store is garbage until loaded.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4_top
   import mi44_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [ENTRY_W-1:0]  req_entry_value,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [THR_W-1:0]           csr_singular_threshold,
   output logic                       rsp_strobe,
   output logic signed [ENTRY_W-1:0]  rsp_result_value,
   output logic                       rsp_singular_flag,
   output logic                       rsp_last_entry
);

   state_type state_ff, state_in;
   logic [3:0] load_count_ff, load_count_in;
   logic [THR_W-1:0] thr_ff;
   logic [3:0] ci_ff, ci_in;
   logic [2:0] term_ff, term_in;
   logic signed [ENTRY_W-1:0] ea_ff, ea_in, eb_ff, eb_in, ec_ff, ec_in;
   logic [ENTRY_W-1:0] phi_ff, phi_in;
   logic signed [65:0] mprod_ff;
   logic signed [32:0] mul_a, mul_b;
   logic signed [DET_W-1:0] acc_ff, acc_in, addend;
   logic [2:0] limb_ff, limb_in;
   logic [COF_W-1:0] cw_ff, cw_in;
   logic [DET_W-1:0] dabs_ff, dabs_in;
   logic det_neg_ff, det_neg_in;
   logic singular_ff, singular_in;
   logic [3:0] k_ff, k_in;
   logic [COF_W-1:0] num_abs_ff, num_abs_in;
   logic qneg_ff, qneg_in, sat_ff, sat_in;
   logic [DET_W:0] rem_ff, rem_in, rem2;
   logic [ENTRY_W-1:0] q_ff, q_in;
   logic [4:0] bit_ff, bit_in;
   logic strobe_ff, strobe_in, flag_ff, flag_in, last_ff, last_in;
   logic [ENTRY_W-1:0] value_ff, value_in;
   logic big;

   // memories
   logic [ENTRY_W-1:0] entry_mem [16];
   logic [COF_W-1:0]   cof_mem [16];
   logic signed [ENTRY_W-1:0] ent_q_ff;
   logic [COF_W-1:0] cof_q_ff;
   logic [3:0] ent_raddr, cof_raddr;
   logic ent_we, cof_we;
   logic [COF_W-1:0] cof_wdata;

   always_ff @(posedge clock) begin
      if (ent_we)
         entry_mem[load_count_ff] <= req_entry_value;
      ent_q_ff <= entry_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (cof_we)
         cof_mem[ci_ff] <= cof_wdata;
      cof_q_ff <= cof_mem[cof_raddr];
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_strobe        = strobe_ff;
   assign rsp_result_value  = value_ff;
   assign rsp_singular_flag = flag_ff;
   assign rsp_last_entry    = last_ff;

   assign rem2 = {rem_ff[DET_W-1:0], 1'b0};
   assign big  = sat_ff | q_ff[ENTRY_W-1];

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      ci_in         = ci_ff;
      term_in       = term_ff;
      ea_in         = ea_ff;
      eb_in         = eb_ff;
      ec_in         = ec_ff;
      phi_in        = phi_ff;
      acc_in        = acc_ff;
      limb_in       = limb_ff;
      cw_in         = cw_ff;
      dabs_in       = dabs_ff;
      det_neg_in    = det_neg_ff;
      singular_in   = singular_ff;
      k_in          = k_ff;
      num_abs_in    = num_abs_ff;
      qneg_in       = qneg_ff;
      sat_in        = sat_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      bit_in        = bit_ff;
      strobe_in     = 1'b0;
      flag_in       = flag_ff;
      last_in       = 1'b0;
      value_in      = value_ff;
      mul_a         = '0;
      mul_b         = '0;
      addend        = '0;
      ent_raddr     = '0;
      cof_raddr     = '0;
      ent_we        = 1'b0;
      cof_we        = 1'b0;
      cof_wdata     = (ci_ff[2] ^ ci_ff[0]) ? COF_W'(-acc_ff) : COF_W'(acc_ff);

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ent_we        = 1'b1;
               load_count_in = 4'(load_count_ff + 4'd1);
               if (load_count_ff == 4'd15) begin
                  state_in = ST_RA;
                  ci_in    = '0;
                  term_in  = '0;
                  acc_in   = '0;
               end
            end
         end
         ST_RA: begin
            ent_raddr = minor_addr(ci_ff, term_ff, 2'd0);
            state_in  = ST_RB;
         end
         ST_RB: begin
            ent_raddr = minor_addr(ci_ff, term_ff, 2'd1);
            ea_in     = ent_q_ff;
            state_in  = ST_RC;
         end
         ST_RC: begin
            ent_raddr = minor_addr(ci_ff, term_ff, 2'd2);
            eb_in     = ent_q_ff;
            state_in  = ST_MP;
         end
         ST_MP: begin
            ec_in    = ent_q_ff;
            mul_a    = 33'(ea_ff);
            mul_b    = 33'(eb_ff);
            state_in = ST_ML;
         end
         ST_ML: begin
            // low half of the pair product times the third factor
            mul_a    = {1'b0, mprod_ff[31:0]};
            mul_b    = 33'(ec_ff);
            phi_in   = mprod_ff[63:32];
            state_in = ST_MH;
         end
         ST_MH: begin
            addend   = DET_W'(mprod_ff);
            acc_in   = PERM_NEG[term_ff] ? acc_ff - addend : acc_ff + addend;
            mul_a    = 33'($signed(phi_ff));
            mul_b    = 33'(ec_ff);
            state_in = ST_AH;
         end
         ST_AH: begin
            addend = DET_W'(mprod_ff) <<< 32;
            acc_in = PERM_NEG[term_ff] ? acc_ff - addend : acc_ff + addend;
            if (term_ff == 3'd5) begin
               state_in = ST_WC;
            end else begin
               term_in  = 3'(term_ff + 3'd1);
               state_in = ST_RA;
            end
         end
         ST_WC: begin
            cof_we  = 1'b1;
            acc_in  = '0;
            term_in = '0;
            if (ci_ff == 4'd15) begin
               ci_in    = '0;
               state_in = ST_DA;
            end else begin
               ci_in    = 4'(ci_ff + 4'd1);
               state_in = ST_RA;
            end
         end
         ST_DA: begin
            ent_raddr = {2'b00, ci_ff[1:0]};
            cof_raddr = {2'b00, ci_ff[1:0]};
            limb_in   = '0;
            state_in  = ST_DB;
         end
         ST_DB: begin
            ea_in    = ent_q_ff;
            cw_in    = cof_q_ff;
            state_in = ST_DL;
         end
         ST_DL: begin
            // multiply limb l while adding limb l-1's product
            if (limb_ff < 3'd4) begin
               if (limb_ff == 3'd3)
                  mul_a = {cw_ff[COF_W-1], cw_ff[COF_W-1 -: 32]};
               else
                  mul_a = {1'b0, cw_ff[32*limb_ff[1:0] +: 32]};
               mul_b = 33'(ea_ff);
            end
            if (limb_ff != 3'd0) begin
               addend = DET_W'(mprod_ff) <<< (32 * 2'(limb_ff - 3'd1));
               acc_in = acc_ff + addend;
            end
            limb_in = 3'(limb_ff + 3'd1);
            if (limb_ff == 3'd4) begin
               if (ci_ff[1:0] == 2'd3) begin
                  state_in = ST_ABS;
               end else begin
                  ci_in    = 4'(ci_ff + 4'd1);
                  state_in = ST_DA;
               end
            end
         end
         ST_ABS: begin
            dabs_in    = acc_ff[DET_W-1] ? DET_W'(-acc_ff) : DET_W'(acc_ff);
            det_neg_in = acc_ff[DET_W-1];
            state_in   = ST_CHK;
         end
         ST_CHK: begin
            singular_in = (dabs_ff == '0) || (dabs_ff < DET_W'(thr_ff));
            k_in        = '0;
            state_in    = ((dabs_ff == '0) || (dabs_ff < DET_W'(thr_ff))) ?
                          ST_SOUT : ST_QA;
         end
         ST_SOUT: begin
            strobe_in = 1'b1;
            flag_in   = 1'b1;
            value_in  = (k_ff[3:2] == k_ff[1:0]) ? ONE_Q : '0;
            last_in   = (k_ff == 4'd15);
            k_in      = 4'(k_ff + 4'd1);
            if (k_ff == 4'd15)
               state_in = ST_IDLE;
         end
         ST_QA: begin
            cof_raddr = {k_ff[1:0], k_ff[3:2]};  // transposed
            state_in  = ST_QB;
         end
         ST_QB: begin
            num_abs_in = cof_q_ff[COF_W-1] ? COF_W'(~cof_q_ff + 1'b1) : cof_q_ff;
            qneg_in    = cof_q_ff[COF_W-1] ^ det_neg_ff;
            state_in   = ST_QC;
         end
         ST_QC: begin
            // quotient reaches 2^32 when |cof| >= |det|
            sat_in   = (DET_W'(num_abs_ff) >= dabs_ff);
            rem_in   = (DET_W+1)'(num_abs_ff);
            q_in     = '0;
            bit_in   = '0;
            state_in = (DET_W'(num_abs_ff) >= dabs_ff) ? ST_QOUT : ST_QDIV;
         end
         ST_QDIV: begin
            if (rem2 >= {1'b0, dabs_ff}) begin
               rem_in = rem2 - {1'b0, dabs_ff};
               q_in   = {q_ff[ENTRY_W-2:0], 1'b1};
            end else begin
               rem_in = rem2;
               q_in   = {q_ff[ENTRY_W-2:0], 1'b0};
            end
            bit_in = 5'(bit_ff + 5'd1);
            if (bit_ff == 5'd31)
               state_in = ST_QOUT;
         end
         ST_QOUT: begin
            strobe_in = 1'b1;
            flag_in   = 1'b0;
            last_in   = (k_ff == 4'd15);
            if (qneg_ff)
               value_in = big ? SAT_NEG : ENTRY_W'(~q_ff + 1'b1);
            else
               value_in = big ? SAT_POS : q_ff;
            k_in = 4'(k_ff + 4'd1);
            state_in = (k_ff == 4'd15) ? ST_IDLE : ST_QA;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mprod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_count_ff <= '0;
         thr_ff        <= THR_RESET;
         strobe_ff     <= 1'b0;
         last_ff       <= 1'b0;
         flag_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         if (csr_valid && csr_ready)
            thr_ff <= csr_singular_threshold;
         strobe_ff     <= strobe_in;
         last_ff       <= last_in;
         flag_ff       <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      ci_ff       <= ci_in;
      term_ff     <= term_in;
      ea_ff       <= ea_in;
      eb_ff       <= eb_in;
      ec_ff       <= ec_in;
      phi_ff      <= phi_in;
      acc_ff      <= acc_in;
      limb_ff     <= limb_in;
      cw_ff       <= cw_in;
      dabs_ff     <= dabs_in;
      det_neg_ff  <= det_neg_in;
      singular_ff <= singular_in;
      k_ff        <= k_in;
      num_abs_ff  <= num_abs_in;
      qneg_ff     <= qneg_in;
      sat_ff      <= sat_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      bit_ff      <= bit_in;
      value_ff    <= value_in;
   end

   // results only come out of the compute phase
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == ST_SOUT || state_ff == ST_QOUT))
      else $error("result strobe without an output state");

   a_last_strobe: assert property (@(posedge clock) disable iff (reset)
      last_ff |-> strobe_ff)
      else $error("last flag without strobe");

   // the load count wraps to zero on the same edge that the sequencer leaves idle
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> load_count_ff == 4'd0)
      else $error("load count nonzero while computing");

   a_singular_val: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && flag_ff) |-> (value_ff == ONE_Q || value_ff == '0))
      else $error("singular result not an identity entry");

   a_flag_match: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && $past(state_ff == ST_SOUT)) |-> $past(singular_ff))
      else $error("identity emitted for a regular matrix");

endmodule
